// File: design/crcfr_pkg.sv
// ----------------------------------------------------------------------------
// crcfr_pkg
// Types, codes and reset values shared by the CRC-16 frame receiver.
// ----------------------------------------------------------------------------
package crcfr_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 1024;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned OUT_USER_W = 2;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [7:0]  START_BYTE_RST = 8'hAA;
  localparam logic [7:0]  WANTED_CMD_RST = 8'h00;
  localparam logic [31:0] TIMEOUT_RST    = 32'd1000;
  localparam logic [10:0] COPY_LIMIT_RST = 11'd1024;
  localparam logic [15:0] CRC_SEED_RST   = 16'hFFFF;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_START_BYTE = 3'd0,
    REG_WANTED_CMD = 3'd1,
    REG_TIMEOUT    = 3'd2,
    REG_COPY_LIMIT = 3'd3,
    REG_CRC_SEED   = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ACT_ARM  = 2'd0,
    ACT_BYTE = 2'd1,
    ACT_TICK = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_CRC_ERR = 2'd2,
    KIND_TIMEOUT = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_CMD   = 3'd1,
    PH_LEN_H = 3'd2,
    PH_LEN_L = 3'd3,
    PH_DATA  = 3'd4,
    PH_CRC_H = 3'd5,
    PH_CRC_L = 3'd6
  } phase_t;

  // CRC-16, poly 0x1021, MSB first, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// File: design/crc16_frame_receiver.sv
// ----------------------------------------------------------------------------
// crc16_frame_receiver
// Deframes start/command/length/payload/CRC-16 frames from a byte stream,
// passes payload bytes out and reports good, CRC error or timeout.
// ----------------------------------------------------------------------------
// Channel   Dir  Fields (low bit up)
// in_*      in   tuser: action[1:0]; tdata: rx_byte[7:0]
// out_*     out  tuser: kind[1:0]; tlast: last;
//                tdata: data_byte[7:0], byte_index[17:8], frame_command[25:18],
//                       frame_length[36:26], zero pad[39:37]
// cfg_*     in   we, addr (register index), wdata
//
// One item per cycle while in_tready is high; results load into the
// output register on accept. The path is the state update, a byte-wide
// CRC-16 step and the 32-bit tick add and compare. in_tready stays high
// while the output register is empty or being drained. Synchronous
// active-low reset disarms the receiver and loads register defaults.
// ----------------------------------------------------------------------------
module crc16_frame_receiver #(
  parameter int unsigned MAX_PAYLOAD = crcfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [crcfr_pkg::IN_DATA_W-1:0]     in_tdata,   // rx_byte
  input  logic [crcfr_pkg::IN_USER_W-1:0]     in_tuser,   // action
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // data_byte, byte_index, frame_command, frame_length, zero pad
  output logic [crcfr_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [crcfr_pkg::OUT_USER_W-1:0]    out_tuser,  // kind
  output logic                                out_tlast,
  input  logic                                cfg_we,
  input  logic [crcfr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [crcfr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import crcfr_pkg::*;

  logic [7:0]  start_byte_r;
  logic [7:0]  wanted_cmd_r;
  logic [31:0] timeout_r;
  logic [10:0] copy_limit_r;
  logic [15:0] crc_seed_r;

  phase_t      phase_r, phase_nxt;
  logic        armed_r, armed_nxt;
  logic [7:0]  held_cmd_r, held_cmd_nxt;
  logic [15:0] held_len_r, held_len_nxt;
  logic [15:0] pay_cnt_r, pay_cnt_nxt;
  logic [15:0] run_crc_r, run_crc_nxt;
  logic [15:0] rx_crc_r, rx_crc_nxt;
  logic [31:0] tick_cnt_r, tick_cnt_nxt;

  logic        out_valid_r, out_valid_nxt;
  kind_t       out_kind_r, out_kind_nxt;
  logic [7:0]  out_data_r, out_data_nxt;
  logic [9:0]  out_idx_r, out_idx_nxt;
  logic [7:0]  out_cmd_r, out_cmd_nxt;
  logic [10:0] out_len_r, out_len_nxt;
  logic        out_last_r, out_last_nxt;

  logic        acc;
  logic        emit;
  logic        cmd_match;
  logic [7:0]  b;
  logic [15:0] cnt_inc;
  logic [15:0] len_full;
  logic [15:0] rx_crc_full;

  assign in_tready  = !out_valid_r || out_tready;
  assign acc        = in_tvalid && in_tready;
  assign b          = in_tdata;
  assign cmd_match  = (wanted_cmd_r == 8'd0) || (held_cmd_r == wanted_cmd_r);
  assign cnt_inc    = pay_cnt_r + 16'd1;
  assign len_full   = {held_len_r[15:8], b};
  assign rx_crc_full = {rx_crc_r[15:8], b};

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_len_r, out_cmd_r, out_idx_r, out_data_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= START_BYTE_RST;
      wanted_cmd_r <= WANTED_CMD_RST;
      timeout_r    <= TIMEOUT_RST;
      copy_limit_r <= COPY_LIMIT_RST;
      crc_seed_r   <= CRC_SEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_START_BYTE: start_byte_r <= cfg_wdata[7:0];
        REG_WANTED_CMD: wanted_cmd_r <= cfg_wdata[7:0];
        REG_TIMEOUT:    timeout_r    <= cfg_wdata;
        REG_COPY_LIMIT: copy_limit_r <= cfg_wdata[10:0];
        REG_CRC_SEED:   crc_seed_r   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    armed_nxt    = armed_r;
    held_cmd_nxt = held_cmd_r;
    held_len_nxt = held_len_r;
    pay_cnt_nxt  = pay_cnt_r;
    run_crc_nxt  = run_crc_r;
    rx_crc_nxt   = rx_crc_r;
    tick_cnt_nxt = tick_cnt_r;
    emit         = 1'b0;
    out_kind_nxt = KIND_PAYLOAD;
    out_data_nxt = 8'd0;
    out_idx_nxt  = 10'd0;
    out_cmd_nxt  = held_cmd_r;
    out_len_nxt  = held_len_r[10:0];
    out_last_nxt = 1'b0;

    if (acc) begin
      unique case (in_tuser)
        ACT_ARM: begin
          armed_nxt    = 1'b1;
          phase_nxt    = PH_HUNT;
          tick_cnt_nxt = 32'd0;
          pay_cnt_nxt  = 16'd0;
          run_crc_nxt  = crc_seed_r;
        end
        ACT_TICK: begin
          if (armed_r) begin
            if (tick_cnt_r != 32'hFFFF_FFFF) begin
              tick_cnt_nxt = tick_cnt_r + 32'd1;
            end
            if (tick_cnt_nxt >= timeout_r) begin
              armed_nxt    = 1'b0;
              phase_nxt    = PH_HUNT;
              emit         = 1'b1;
              out_kind_nxt = KIND_TIMEOUT;
              out_cmd_nxt  = 8'd0;
              out_len_nxt  = 11'd0;
              out_last_nxt = 1'b1;
            end
          end
        end
        ACT_BYTE: begin
          if (armed_r) begin
            unique case (phase_r)
              PH_HUNT: begin
                if (b == start_byte_r) begin
                  phase_nxt = PH_CMD;
                end
              end
              PH_CMD: begin
                held_cmd_nxt = b;
                phase_nxt    = PH_LEN_H;
              end
              PH_LEN_H: begin
                held_len_nxt = {b, 8'd0};
                phase_nxt    = PH_LEN_L;
              end
              PH_LEN_L: begin
                held_len_nxt = len_full;
                run_crc_nxt  = crc_seed_r;
                pay_cnt_nxt  = 16'd0;
                priority if (len_full > 16'(MAX_PAYLOAD)) begin
                  phase_nxt = PH_HUNT;
                end else if (len_full == 16'd0) begin
                  phase_nxt = PH_CRC_H;
                end else begin
                  phase_nxt = PH_DATA;
                end
              end
              PH_DATA: begin
                run_crc_nxt = crc16_byte(run_crc_r, b);
                pay_cnt_nxt = cnt_inc;
                if (cnt_inc >= held_len_r) begin
                  phase_nxt = PH_CRC_H;
                end
                if (cmd_match && (pay_cnt_r < {5'd0, copy_limit_r})) begin
                  emit         = 1'b1;
                  out_kind_nxt = KIND_PAYLOAD;
                  out_data_nxt = b;
                  out_idx_nxt  = pay_cnt_r[9:0];
                end
              end
              PH_CRC_H: begin
                rx_crc_nxt = {b, 8'd0};
                phase_nxt  = PH_CRC_L;
              end
              PH_CRC_L: begin
                rx_crc_nxt = rx_crc_full;
                phase_nxt  = PH_HUNT;
                if (cmd_match) begin
                  armed_nxt    = 1'b0;
                  emit         = 1'b1;
                  out_kind_nxt = (run_crc_r == rx_crc_full) ? KIND_GOOD : KIND_CRC_ERR;
                  out_last_nxt = 1'b1;
                end
              end
              default: phase_nxt = PH_HUNT;
            endcase
          end
        end
        default: ;
      endcase
    end

    if (acc) begin
      out_valid_nxt = emit;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      armed_r     <= 1'b0;
      held_cmd_r  <= 8'd0;
      held_len_r  <= 16'd0;
      pay_cnt_r   <= 16'd0;
      run_crc_r   <= CRC_SEED_RST;
      rx_crc_r    <= 16'd0;
      tick_cnt_r  <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      armed_r     <= armed_nxt;
      held_cmd_r  <= held_cmd_nxt;
      held_len_r  <= held_len_nxt;
      pay_cnt_r   <= pay_cnt_nxt;
      run_crc_r   <= run_crc_nxt;
      rx_crc_r    <= rx_crc_nxt;
      tick_cnt_r  <= tick_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, loaded on accept
  always_ff @(posedge clk) begin
    if (acc) begin
      out_kind_r <= out_kind_nxt;
      out_data_r <= out_data_nxt;
      out_idx_r  <= out_idx_nxt;
      out_cmd_r  <= out_cmd_nxt;
      out_len_r  <= out_len_nxt;
      out_last_r <= out_last_nxt;
    end
  end

endmodule
